[design/sorted_set_with_odd_partition_assert.svh]
// assertion macros for the sorted set block
// used by the top level; no other dependencies
`ifndef SORTED_SET_WITH_ODD_PARTITION_ASSERT_SVH
`define SORTED_SET_WITH_ODD_PARTITION_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define SSOP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssop assertion failed");

// next-cycle implication, checked out of reset
`define SSOP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssop assertion failed");

`else

`define SSOP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SSOP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[design/ssop_pkg.sv]
// shared types, sizes and codes for the sorted set block
// no dependencies
`default_nettype none

package ssop_pkg;

    // store geometry
    localparam int DEPTH       = 32;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int MAX_RESULTS = 32;

    // field widths
    localparam int ELEM_W     = 32;
    localparam int POS_W      = 5;
    localparam int STAT_W     = 3;
    localparam int OUT_DATA_W = 40;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [POS_W-1:0]         t_pos;
    typedef logic [STAT_W-1:0]        t_stat;
    typedef logic [1:0]               t_op;

    // input kinds
    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_READOUT = 1'b1;

    // result status codes
    localparam t_stat ST_INSERTED  = 3'd0;
    localparam t_stat ST_DUPLICATE = 3'd1;
    localparam t_stat ST_FULL      = 3'd2;
    localparam t_stat ST_ELEMENT   = 3'd3;
    localparam t_stat ST_EMPTY     = 3'd4;

    // cell operations
    localparam t_op OP_HOLD = 2'd0;
    localparam t_op OP_CMP  = 2'd1;
    localparam t_op OP_INS  = 2'd2;
    localparam t_op OP_ROT  = 2'd3;

    localparam t_cnt COUNT_FULL = t_cnt'(DEPTH);

    // broadcast to every cell
    typedef struct packed {
        t_op   op;
        t_elem value;
    } t_cmd;

    // summary of the row back to the controller
    typedef struct packed {
        logic  dup;
        t_idx  pos;
        t_elem head;
    } t_chain_stat;

endpackage

`default_nettype wire

[design/sorted_set_with_odd_partition.sv]
// top level of the sorted set with even-first readout: control and output word
// depends on ssop_pkg, ssop_chain and the assertion macro header
//
// channel  | dir | tdata                          | tuser      | tlast
// s input  | in  | value[31:0]                    | kind       | -
// m result | out | position[4:0], element[36:5]   | status     | last
//
// an insert broadcasts a compare, then shifts the row open unless duplicate or full
// a readout makes two full rotations of the row, one element examined per cycle
// while the result is free; an empty readout returns a single empty result
// the block takes a new word only when idle; a held result stalls the sequence
// reset clears the fill count and control; cell contents are left as they are
`default_nettype none

`include "sorted_set_with_odd_partition_assert.svh"

module sorted_set_with_odd_partition (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [ssop_pkg::ELEM_W-1:0]       i_s_tdata,   // value[31:0]
    input  wire logic                              i_s_tuser,   // kind[0]
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [ssop_pkg::OUT_DATA_W-1:0]        o_m_tdata,   // position[4:0], element[36:5]
    output logic [ssop_pkg::STAT_W-1:0]            o_m_tuser,   // status[2:0]
    output logic                                   o_m_tlast
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;

    logic [1:0]            r_state, n_state;
    ssop_pkg::t_cnt        r_count, n_count;
    ssop_pkg::t_elem       r_ins_value, n_ins_value;
    logic                  r_pass, n_pass;
    ssop_pkg::t_idx        r_step, n_step;
    ssop_pkg::t_cnt        r_n, n_n;

    logic                  r_out_valid, n_out_valid;
    ssop_pkg::t_stat       r_out_status, n_out_status;
    ssop_pkg::t_pos        r_out_pos, n_out_pos;
    ssop_pkg::t_elem       r_out_elem, n_out_elem;
    logic                  r_out_last, n_out_last;

    ssop_pkg::t_cmd        w_cmd;
    ssop_pkg::t_chain_stat w_stat;
    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_step_end;
    ssop_pkg::t_cnt        w_emit_total;
    logic                  w_ins_accept;
    logic                  w_rd_final;
    logic                  w_single_out;

    ssop_chain u_chain (
        .i_clk   (i_clk),
        .i_cmd   (w_cmd),
        .i_count (r_count),
        .o_stat  (w_stat)
    );

    // handshakes
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    // readout bookkeeping
    assign w_step_end   = ({1'b0, r_step} == (r_count - 1'b1));
    assign w_emit_total = (int'(r_count) > ssop_pkg::MAX_RESULTS) ?
                          ssop_pkg::t_cnt'(ssop_pkg::MAX_RESULTS) : r_count;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ins_value  = r_ins_value;
        n_pass       = r_pass;
        n_step       = r_step;
        n_n          = r_n;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        n_out_elem   = r_out_elem;
        n_out_last   = r_out_last;
        w_cmd.op     = ssop_pkg::OP_HOLD;
        w_cmd.value  = r_ins_value;
        case (r_state)
            S_IDLE: begin
                w_cmd.value = i_s_tdata;
                if (w_accept) begin
                    if (i_s_tuser == ssop_pkg::KIND_INSERT) begin
                        w_cmd.op    = ssop_pkg::OP_CMP;
                        n_ins_value = i_s_tdata;
                        n_state     = S_INS;
                    end else begin
                        n_pass  = 1'b0;
                        n_step  = '0;
                        n_n     = '0;
                        n_state = S_RD;
                    end
                end
            end
            S_INS: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = '0;
                    n_out_elem  = '0;
                    n_out_last  = 1'b1;
                    if (w_stat.dup) begin
                        n_out_status = ssop_pkg::ST_DUPLICATE;
                    end else if (r_count == ssop_pkg::COUNT_FULL) begin
                        n_out_status = ssop_pkg::ST_FULL;
                    end else begin
                        w_cmd.op     = ssop_pkg::OP_INS;
                        n_count      = r_count + 1'b1;
                        n_out_status = ssop_pkg::ST_INSERTED;
                        n_out_pos    = ssop_pkg::t_pos'(w_stat.pos);
                    end
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                if (w_out_free) begin
                    if (r_count == '0) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ssop_pkg::ST_EMPTY;
                        n_out_pos    = '0;
                        n_out_elem   = '0;
                        n_out_last   = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        w_cmd.op = ssop_pkg::OP_ROT;
                        // even pass first, odd pass second
                        if ((w_stat.head[0] == r_pass) && (r_n < w_emit_total)) begin
                            n_out_valid  = 1'b1;
                            n_out_status = ssop_pkg::ST_ELEMENT;
                            n_out_pos    = ssop_pkg::t_pos'(r_n);
                            n_out_elem   = w_stat.head;
                            n_out_last   = (r_n == w_emit_total - 1'b1);
                            n_n          = r_n + 1'b1;
                        end
                        if (w_step_end) begin
                            n_step = '0;
                            if (r_pass) begin
                                n_count = '0;
                                n_state = S_IDLE;
                            end else begin
                                n_pass = 1'b1;
                            end
                        end else begin
                            n_step = r_step + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pass      <= 1'b0;
            r_step      <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pass      <= n_pass;
            r_step      <= n_step;
            r_n         <= n_n;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ins_value  <= n_ins_value;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
        r_out_elem   <= n_out_elem;
        r_out_last   <= n_out_last;
    end

    // result word
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_elem, r_out_pos};
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

    // terms for the checks
    assign w_ins_accept = w_accept && (i_s_tuser == ssop_pkg::KIND_INSERT);
    assign w_rd_final   = (r_state == S_RD) && w_out_free && r_pass && w_step_end &&
                          (r_count != '0);
    assign w_single_out = o_m_tvalid && (o_m_tuser != ssop_pkg::ST_ELEMENT);

    // checks
    `SSOP_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= ssop_pkg::COUNT_FULL)
    `SSOP_ASSERT_NEXT(a_insert_to_shift, i_clk, i_rst_n, w_ins_accept, r_state == S_INS)
    `SSOP_ASSERT_NEXT(a_readout_clears, i_clk, i_rst_n, w_rd_final, r_count == '0)
    `SSOP_ASSERT_IMPLY(a_single_result_last, i_clk, i_rst_n, w_single_out, o_m_tlast)

endmodule

`default_nettype wire

[design/ssop_cell.sv]
// one cell of the sorted row: holds one entry and its compare flags
// depends on ssop_pkg
`default_nettype none

module ssop_cell (
    input  wire logic             i_clk,
    input  wire ssop_pkg::t_cmd   i_cmd,
    input  wire logic             i_valid,
    input  wire logic             i_prev_lt,
    input  wire ssop_pkg::t_elem  i_prev_value,
    input  wire ssop_pkg::t_elem  i_next_value,
    output ssop_pkg::t_elem       o_value,
    output logic                  o_lt,
    output logic                  o_eq
);

    ssop_pkg::t_elem r_value, n_value;
    logic            r_lt, n_lt;
    logic            r_eq, n_eq;

    // entry update: latch compare flags on compare, open a slot on insert, shift down on rotate
    always_comb begin
        n_value = r_value;
        n_lt    = r_lt;
        n_eq    = r_eq;
        case (i_cmd.op)
            ssop_pkg::OP_CMP: begin
                n_lt = i_valid && (r_value < i_cmd.value);
                n_eq = i_valid && (r_value == i_cmd.value);
            end
            ssop_pkg::OP_INS: begin
                if (!r_lt) begin
                    n_value = i_prev_lt ? i_cmd.value : i_prev_value;
                end
            end
            ssop_pkg::OP_ROT: begin
                n_value = i_next_value;
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_lt    <= n_lt;
        r_eq    <= n_eq;
    end

    assign o_value = r_value;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

`default_nettype wire

[design/ssop_chain.sv]
// row of sorted cells with neighbor links, slot encoder and duplicate flag
// depends on ssop_pkg and ssop_cell
`default_nettype none

module ssop_chain (
    input  wire logic                  i_clk,
    input  wire ssop_pkg::t_cmd        i_cmd,
    input  wire ssop_pkg::t_cnt        i_count,
    output ssop_pkg::t_chain_stat      o_stat
);

    ssop_pkg::t_elem w_value [ssop_pkg::DEPTH];
    ssop_pkg::t_elem w_next  [ssop_pkg::DEPTH];
    logic [ssop_pkg::DEPTH-1:0] w_lt;
    logic [ssop_pkg::DEPTH-1:0] w_eq;
    logic [ssop_pkg::DEPTH-1:0] w_valid;
    logic [ssop_pkg::DEPTH-1:0] w_prev_lt;
    logic [ssop_pkg::DEPTH-1:0] w_slot;
    ssop_pkg::t_idx             w_pos;

    genvar g;
    generate
        for (g = 0; g < ssop_pkg::DEPTH; g++) begin : g_cell
            // a cell is live below the fill count
            assign w_valid[g] = ssop_pkg::t_cnt'(g) < i_count;

            // rotate link: the last live cell wraps to the head
            if (g == ssop_pkg::DEPTH - 1) begin : g_tail
                assign w_next[g] = w_value[0];
            end else begin : g_mid
                assign w_next[g] = (ssop_pkg::t_cnt'(g + 1) == i_count) ?
                                   w_value[0] : w_value[g+1];
            end

            // insert link from the lower neighbor
            if (g == 0) begin : g_head
                assign w_prev_lt[g] = 1'b1;
                ssop_cell u_cell (
                    .i_clk        (i_clk),
                    .i_cmd        (i_cmd),
                    .i_valid      (w_valid[g]),
                    .i_prev_lt    (w_prev_lt[g]),
                    .i_prev_value (i_cmd.value),
                    .i_next_value (w_next[g]),
                    .o_value      (w_value[g]),
                    .o_lt         (w_lt[g]),
                    .o_eq         (w_eq[g])
                );
            end else begin : g_body
                assign w_prev_lt[g] = w_lt[g-1];
                ssop_cell u_cell (
                    .i_clk        (i_clk),
                    .i_cmd        (i_cmd),
                    .i_valid      (w_valid[g]),
                    .i_prev_lt    (w_prev_lt[g]),
                    .i_prev_value (w_value[g-1]),
                    .i_next_value (w_next[g]),
                    .o_value      (w_value[g]),
                    .o_lt         (w_lt[g]),
                    .o_eq         (w_eq[g])
                );
            end

            // the insert slot is where the less-than run ends
            assign w_slot[g] = !w_lt[g] && w_prev_lt[g];
        end
    endgenerate

    // one-hot slot to index
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < ssop_pkg::DEPTH; i++) begin
            if (w_slot[i]) begin
                w_pos = w_pos | ssop_pkg::t_idx'(i);
            end
        end
    end

    assign o_stat.pos  = w_pos;
    assign o_stat.dup  = |w_eq;
    assign o_stat.head = w_value[0];

endmodule

`default_nettype wire
